>>> hdl/lmts_pkg.sv
// Shared types, timing constants and codes for the LCD mode timing sequencer.
// No dependencies; every other file refers to this package by scoped names.
package lmts_pkg;

    // Line and frame timing, in dot clocks and lines
    localparam int LINE_DOTS       = 456;
    localparam int OAM_SCAN_DOTS   = 80;
    localparam int DRAW_MIN_DOTS   = 172;
    localparam int LINES_PER_FRAME = 154;
    localparam int VISIBLE_LINES   = 144;
    localparam int MAX_STEP_DOTS   = 63;

    // Field widths
    localparam int DOTS_W  = 6;
    localparam int COUNT_W = 10;
    localparam int LINE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 8;
    localparam int IN_TW   = 8;
    localparam int OUT_TW  = 16;

    localparam logic [COUNT_W-1:0] DOT_MAX = {COUNT_W{1'b1}};

    // LCD mode codes
    localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_IRQ_HBLANK = 3'd0;
    localparam logic [CFG_AW-1:0] REG_IRQ_VBLANK = 3'd1;
    localparam logic [CFG_AW-1:0] REG_IRQ_OAM    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_IRQ_MATCH  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_LINE_CMP   = 3'd4;

    typedef struct packed {
        logic              irq_on_hblank;
        logic              irq_on_vblank;
        logic              irq_on_oam_scan;
        logic              irq_on_line_match;
        logic [LINE_W-1:0] line_compare;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] dot_count;
        logic [MODE_W-1:0]  mode;
        logic [LINE_W-1:0]  line;
        logic               irq_line_prev;
    } timing_state_t;

    typedef struct packed {
        logic              line_ready;
        logic              vblank_irq;
        logic              stat_irq;
        logic              line_match;
        logic [LINE_W-1:0] current_line;
        logic [MODE_W-1:0] lcd_mode;
    } result_t;

endpackage

>>> hdl/lmts_cfg_regs.sv
// Configuration register file: interrupt enables and line compare value.
// Depends on lmts_pkg.
module lmts_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lmts_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [lmts_pkg::CFG_DW-1:0]    cfg_wdata,
    output lmts_pkg::cfg_t                 cfg
);

    lmts_pkg::cfg_t cfg_reg;
    lmts_pkg::cfg_t cfg_next;

    // Decode one register write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                lmts_pkg::REG_IRQ_HBLANK: cfg_next.irq_on_hblank     = cfg_wdata[0];
                lmts_pkg::REG_IRQ_VBLANK: cfg_next.irq_on_vblank     = cfg_wdata[0];
                lmts_pkg::REG_IRQ_OAM:    cfg_next.irq_on_oam_scan   = cfg_wdata[0];
                lmts_pkg::REG_IRQ_MATCH:  cfg_next.irq_on_line_match = cfg_wdata[0];
                lmts_pkg::REG_LINE_CMP:   cfg_next.line_compare      = cfg_wdata;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/lmts_step.sv
// Single-update timing logic: dot accumulation, one mode transition,
// line compare and status interrupt edge detect. Depends on lmts_pkg.
module lmts_step
(
    input  logic [lmts_pkg::DOTS_W-1:0] dots_elapsed,
    input  lmts_pkg::timing_state_t     state,
    input  lmts_pkg::cfg_t              cfg,
    output lmts_pkg::timing_state_t     state_next,
    output lmts_pkg::result_t           result
);

    localparam int SUM_W = lmts_pkg::COUNT_W + 1;
    localparam logic [lmts_pkg::DOTS_W-1:0] STEP_MAX =
        lmts_pkg::DOTS_W'(lmts_pkg::MAX_STEP_DOTS);
    localparam logic [lmts_pkg::COUNT_W-1:0] LINE_DOTS_C =
        lmts_pkg::COUNT_W'(lmts_pkg::LINE_DOTS);
    localparam logic [lmts_pkg::COUNT_W-1:0] OAM_END_C =
        lmts_pkg::COUNT_W'(lmts_pkg::OAM_SCAN_DOTS);
    localparam logic [lmts_pkg::COUNT_W-1:0] DRAW_END_C =
        lmts_pkg::COUNT_W'(lmts_pkg::OAM_SCAN_DOTS + lmts_pkg::DRAW_MIN_DOTS);
    localparam logic [lmts_pkg::LINE_W-1:0] LAST_LINE_C =
        lmts_pkg::LINE_W'(lmts_pkg::LINES_PER_FRAME - 1);
    localparam logic [lmts_pkg::LINE_W-1:0] VIS_LINES_C =
        lmts_pkg::LINE_W'(lmts_pkg::VISIBLE_LINES);

    logic [lmts_pkg::DOTS_W-1:0]  step_dots;
    logic [SUM_W-1:0]             dot_sum;
    logic [lmts_pkg::COUNT_W-1:0] dot_sat;
    logic [lmts_pkg::LINE_W-1:0]  line_inc;
    logic                         vblank_pulse;
    logic                         ready_pulse;
    logic                         match;
    logic                         irq_line;

    // Clamp the step and accumulate with saturation
    always_comb
    begin
        step_dots = (dots_elapsed > STEP_MAX) ? STEP_MAX : dots_elapsed;
        dot_sum   = SUM_W'(state.dot_count) + SUM_W'(step_dots);
        dot_sat   = dot_sum[SUM_W-1] ? lmts_pkg::DOT_MAX : dot_sum[lmts_pkg::COUNT_W-1:0];
        line_inc  = state.line + lmts_pkg::LINE_W'(1);
    end

    // At most one mode transition per update
    always_comb
    begin
        state_next           = state;
        state_next.dot_count = dot_sat;
        vblank_pulse         = 1'b0;
        ready_pulse          = 1'b0;
        case (state.mode)
            lmts_pkg::MODE_HBLANK,
            lmts_pkg::MODE_VBLANK:
            begin
                if (dot_sat > LINE_DOTS_C)
                begin
                    state_next.dot_count = dot_sat - LINE_DOTS_C;
                    state_next.mode      = lmts_pkg::MODE_OAM;
                    state_next.line      = line_inc;
                    if (line_inc > LAST_LINE_C)
                    begin
                        state_next.line = '0;
                    end
                    else if (line_inc >= VIS_LINES_C)
                    begin
                        state_next.mode = lmts_pkg::MODE_VBLANK;
                        vblank_pulse    = (line_inc == VIS_LINES_C);
                    end
                end
            end
            lmts_pkg::MODE_OAM:
            begin
                if (dot_sat > OAM_END_C)
                begin
                    state_next.mode = lmts_pkg::MODE_DRAW;
                end
            end
            default:
            begin
                if (dot_sat > DRAW_END_C)
                begin
                    state_next.mode = lmts_pkg::MODE_HBLANK;
                    ready_pulse     = 1'b1;
                end
            end
        endcase

        // Line coincidence and status interrupt line
        match    = (state_next.line == cfg.line_compare);
        irq_line = (state_next.mode == lmts_pkg::MODE_HBLANK && cfg.irq_on_hblank)
                || (state_next.mode == lmts_pkg::MODE_VBLANK && cfg.irq_on_vblank)
                || (state_next.mode == lmts_pkg::MODE_OAM    && cfg.irq_on_oam_scan)
                || (match && cfg.irq_on_line_match);
        state_next.irq_line_prev = irq_line;

        result.lcd_mode     = state_next.mode;
        result.current_line = state_next.line;
        result.line_match   = match;
        result.stat_irq     = irq_line && !state.irq_line_prev;
        result.vblank_irq   = vblank_pulse;
        result.line_ready   = ready_pulse;
    end

endmodule

>>> hdl/lcd_mode_timing_sequencer_core.sv
// Top level of the LCD mode timing sequencer: input register, timing state,
// result register. Depends on lmts_pkg, lmts_cfg_regs and lmts_step.
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_tvalid / s_tready       s_tdata[5:0] dots_elapsed
//   m_axis    out        m_tvalid / m_tready       m_tdata: mode, line, flags
//   cfg       in         cfg_we (no wait)          cfg_addr, cfg_wdata
//
// One update per clock while the output is not stalled: a transaction lands in the input
// register, then the step logic updates the timing state and fills the result register.
// Reset puts the sequencer at line 0, dot 0, OAM scan, enables cleared.
// A stalled output holds its result; the input register accepts while it is empty
// or while the result register is free or being drained in the same cycle.
module lcd_mode_timing_sequencer_core
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lmts_pkg::IN_TW-1:0]     s_tdata,   // [5:0] dots_elapsed, [7:6] zero

    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lmts_pkg::OUT_TW-1:0]    m_tdata,   // [1:0] lcd_mode, [9:2] current_line,
                                                      // [10] line_match, [11] stat_irq,
                                                      // [12] vblank_irq, [13] line_ready,
                                                      // [15:14] zero

    input  logic                           cfg_we,
    input  logic [lmts_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [lmts_pkg::CFG_DW-1:0]    cfg_wdata
);

    localparam int RES_W = $bits(lmts_pkg::result_t);

    lmts_pkg::cfg_t                cfg;
    lmts_pkg::timing_state_t       state_reg;
    lmts_pkg::timing_state_t       state_next;
    lmts_pkg::result_t             result;
    lmts_pkg::result_t             out_data_reg;
    logic                          out_valid_reg;
    logic                          in_valid_reg;
    logic [lmts_pkg::DOTS_W-1:0]   in_dots_reg;
    logic                          advance;
    logic                          s_fire;

    lmts_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lmts_step u_step
    (
        .dots_elapsed (in_dots_reg),
        .state        (state_reg),
        .cfg          (cfg),
        .state_next   (state_next),
        .result       (result)
    );

    // Handshake: result register free or draining this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_dots_reg <= s_tdata[lmts_pkg::DOTS_W-1:0];
        end
    end

    // Timing state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.dot_count     <= '0;
            state_reg.mode          <= lmts_pkg::MODE_OAM;
            state_reg.line          <= '0;
            state_reg.irq_line_prev <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lmts_pkg::OUT_TW - RES_W){1'b0}}, out_data_reg};

endmodule

>>> hdl/lmts_checker.sv
// Port-level checker for the LCD mode timing sequencer, bound to the top level.
// Depends on lmts_pkg and lcd_mode_timing_sequencer_core.
module lmts_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lmts_pkg::OUT_TW-1:0]    m_tdata
);

    logic [lmts_pkg::MODE_W-1:0] mode;
    logic [lmts_pkg::LINE_W-1:0] line;
    logic                        vblank_irq;
    logic                        line_ready;

    assign mode       = m_tdata[1:0];
    assign line       = m_tdata[9:2];
    assign vblank_irq = m_tdata[12];
    assign line_ready = m_tdata[13];

    // A stalled result holds its payload
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed while stalled");

    // Vblank mode only on the vblank lines
    property p_vblank_lines;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && mode == lmts_pkg::MODE_VBLANK)
            |-> (line >= lmts_pkg::LINE_W'(lmts_pkg::VISIBLE_LINES));
    endproperty
    a_vblank_lines: assert property (p_vblank_lines)
        else $error("vblank mode on a visible line");

    // Vblank pulse only on entry to the first vblank line
    property p_vblank_entry;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && vblank_irq)
            |-> (mode == lmts_pkg::MODE_VBLANK
                 && line == lmts_pkg::LINE_W'(lmts_pkg::VISIBLE_LINES));
    endproperty
    a_vblank_entry: assert property (p_vblank_entry)
        else $error("vblank pulse away from vblank entry");

    // Line ready only when drawing has just ended
    property p_ready_hblank;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && line_ready) |-> (mode == lmts_pkg::MODE_HBLANK && !vblank_irq);
    endproperty
    a_ready_hblank: assert property (p_ready_hblank)
        else $error("line ready outside hblank entry");

endmodule

bind lcd_mode_timing_sequencer_core lmts_checker u_lmts_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

>>> test/lcd_mode_timing_sequencer_core_tb.sv
// Self-checking testbench for lcd_mode_timing_sequencer_core: drives dot-step updates
// and register writes, predicts mode/line/interrupt results and checks each transaction.
// Depends on lmts_pkg and the RTL of the sequencer only.
`timescale 1ns / 100ps

module lcd_mode_timing_sequencer_core_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 125;

    // Timing predictor and store of expected results
    class lcd_timing_scoreboard;
        logic [lmts_pkg::COUNT_W-1:0] dot_count;
        logic [lmts_pkg::MODE_W-1:0]  mode;
        logic [lmts_pkg::LINE_W-1:0]  line;
        logic                         irq_prev;
        logic                         en_hblank;
        logic                         en_vblank;
        logic                         en_oam;
        logic                         en_match;
        logic [lmts_pkg::LINE_W-1:0]  line_cmp;
        lmts_pkg::result_t            expected_q[$];
        int                           errors;
        int                           n_updates;
        int                           n_checked;
        int                           n_vblank;
        int                           n_ready;
        int                           n_stat;
        int                           n_match;
        int                           n_wraps;
        int                           max_line;

        function new();
            dot_count = '0;
            mode      = lmts_pkg::MODE_OAM;
            line      = '0;
            irq_prev  = 1'b0;
            en_hblank = 1'b0;
            en_vblank = 1'b0;
            en_oam    = 1'b0;
            en_match  = 1'b0;
            line_cmp  = '0;
            errors    = 0;
            n_updates = 0;
            n_checked = 0;
            n_vblank  = 0;
            n_ready   = 0;
            n_stat    = 0;
            n_match   = 0;
            n_wraps   = 0;
            max_line  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Register write; unmapped indexes are dropped, upper data bits ignored
        function void write_reg(logic [lmts_pkg::CFG_AW-1:0] idx,
                                logic [lmts_pkg::CFG_DW-1:0] val);
            case (idx)
                lmts_pkg::REG_IRQ_HBLANK: en_hblank = val[0];
                lmts_pkg::REG_IRQ_VBLANK: en_vblank = val[0];
                lmts_pkg::REG_IRQ_OAM:    en_oam    = val[0];
                lmts_pkg::REG_IRQ_MATCH:  en_match  = val[0];
                lmts_pkg::REG_LINE_CMP:   line_cmp  = val;
                default: ;
            endcase
        endfunction

        // One accepted update: advance the timing state and queue its result
        function void note_update(logic [lmts_pkg::DOTS_W-1:0] dots);
            int unsigned       step;
            int unsigned       cnt;
            logic              stat_line;
            lmts_pkg::result_t r;

            r    = '0;
            step = 32'(dots);
            if (step > lmts_pkg::MAX_STEP_DOTS)
                step = lmts_pkg::MAX_STEP_DOTS;
            cnt = dot_count + step;
            if (cnt > lmts_pkg::DOT_MAX)
                cnt = lmts_pkg::DOT_MAX;

            case (mode)
                lmts_pkg::MODE_HBLANK, lmts_pkg::MODE_VBLANK:
                begin
                    if (cnt > lmts_pkg::LINE_DOTS)
                    begin
                        cnt  = cnt - lmts_pkg::LINE_DOTS;
                        line = line + 8'd1;
                        mode = lmts_pkg::MODE_OAM;
                        if (line > lmts_pkg::LINES_PER_FRAME - 1)
                        begin
                            line = '0;
                            n_wraps++;
                        end
                        else if (line >= lmts_pkg::VISIBLE_LINES)
                        begin
                            mode = lmts_pkg::MODE_VBLANK;
                            if (line == lmts_pkg::VISIBLE_LINES)
                                r.vblank_irq = 1'b1;
                        end
                    end
                end
                lmts_pkg::MODE_OAM:
                begin
                    if (cnt > lmts_pkg::OAM_SCAN_DOTS)
                        mode = lmts_pkg::MODE_DRAW;
                end
                default:
                begin
                    if (cnt > lmts_pkg::OAM_SCAN_DOTS + lmts_pkg::DRAW_MIN_DOTS)
                    begin
                        mode         = lmts_pkg::MODE_HBLANK;
                        r.line_ready = 1'b1;
                    end
                end
            endcase
            dot_count = cnt[lmts_pkg::COUNT_W-1:0];

            // Status line is the OR of the enabled sources; drawing mode itself is no source
            r.line_match = (line == line_cmp);
            stat_line    = (mode == lmts_pkg::MODE_HBLANK && en_hblank) ||
                           (mode == lmts_pkg::MODE_VBLANK && en_vblank) ||
                           (mode == lmts_pkg::MODE_OAM    && en_oam)    ||
                           (r.line_match                  && en_match);
            r.stat_irq     = stat_line && !irq_prev;
            irq_prev       = stat_line;
            r.lcd_mode     = mode;
            r.current_line = line;

            n_updates++;
            if (int'(line) > max_line)
                max_line = int'(line);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            end
        endfunction

        // One accepted result transaction against the oldest expectation
        function void check_result(logic [lmts_pkg::OUT_TW-1:0] data);
            lmts_pkg::result_t act;
            lmts_pkg::result_t exp_r;

            act = lmts_pkg::result_t'(data[$bits(lmts_pkg::result_t)-1:0]);
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, data);
                return;
            end
            exp_r = expected_q.pop_front();
            n_checked++;
            n_vblank += exp_r.vblank_irq;
            n_ready  += exp_r.line_ready;
            n_stat   += exp_r.stat_irq;
            n_match  += exp_r.line_match;
            compare_field("lcd_mode",     8'(exp_r.lcd_mode),     8'(act.lcd_mode));
            compare_field("current_line", exp_r.current_line,     act.current_line);
            compare_field("line_match",   8'(exp_r.line_match),   8'(act.line_match));
            compare_field("stat_irq",     8'(exp_r.stat_irq),     8'(act.stat_irq));
            compare_field("vblank_irq",   8'(exp_r.vblank_irq),   8'(act.vblank_irq));
            compare_field("line_ready",   8'(exp_r.line_ready),   8'(act.line_ready));
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [lmts_pkg::IN_TW-1:0]       s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [lmts_pkg::OUT_TW-1:0]      m_tdata;
    logic                             cfg_we;
    logic [lmts_pkg::CFG_AW-1:0]      cfg_addr;
    logic [lmts_pkg::CFG_DW-1:0]      cfg_wdata;

    lcd_timing_scoreboard sb;
    int                   cycles = 0;

    lcd_mode_timing_sequencer_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Mostly large steps so the line count moves quickly
    function automatic logic [lmts_pkg::DOTS_W-1:0] pick_dots();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return lmts_pkg::DOTS_W'($urandom_range(56, lmts_pkg::MAX_STEP_DOTS));
        if (r < 90)
            return lmts_pkg::DOTS_W'($urandom_range(0, lmts_pkg::MAX_STEP_DOTS));
        return lmts_pkg::DOTS_W'($urandom_range(0, 3));
    endfunction

    // Result consumer: random stalls, stretches of always-ready in between
    initial
    begin : result_sink
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("lcd_mode_timing_sequencer_core_tb: FAIL");
            $finish;
        end
    end

    // One update transaction, then an optional idle gap
    task automatic send_update(input logic [lmts_pkg::DOTS_W-1:0] dots, input int gap);
        s_tdata  <= {{(lmts_pkg::IN_TW-lmts_pkg::DOTS_W){1'b0}}, dots};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_update(dots);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [lmts_pkg::CFG_AW-1:0] idx,
                             input logic [lmts_pkg::CFG_DW-1:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Program all registers once the pipeline is drained; 1-bit registers get
    // random upper bits, and a stray write to an unmapped index follows
    task automatic program_regs(input logic hb, input logic vb, input logic oam,
                                input logic mt, input logic [lmts_pkg::LINE_W-1:0] cmp);
        // Stop offering updates while draining
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        write_reg(lmts_pkg::REG_IRQ_HBLANK, {7'($urandom), hb});
        write_reg(lmts_pkg::REG_IRQ_VBLANK, {7'($urandom), vb});
        write_reg(lmts_pkg::REG_IRQ_OAM,    {7'($urandom), oam});
        write_reg(lmts_pkg::REG_IRQ_MATCH,  {7'($urandom), mt});
        write_reg(lmts_pkg::REG_LINE_CMP,   cmp);
        write_reg(lmts_pkg::CFG_AW'($urandom_range(lmts_pkg::REG_LINE_CMP + 1,
                                                   (1 << lmts_pkg::CFG_AW) - 1)),
                  lmts_pkg::CFG_DW'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [lmts_pkg::DOTS_W-1:0] directed_dots [$];
        logic [lmts_pkg::LINE_W-1:0] cmp;
        logic [3:0]                  en;
        int                          r;
        int                          p;
        int                          i;
        bit                          no_gaps;

        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: walk one line hitting each threshold exactly, then one past it
        program_regs(1'b1, 1'b1, 1'b1, 1'b1, 8'd0);
        directed_dots = '{6'd40, 6'd40, 6'd1,                   // OAM scan ends at 81, not 80
                          6'd63, 6'd63, 6'd45, 6'd0, 6'd1,      // drawing ends at 253, not 252
                          6'd63, 6'd63, 6'd63, 6'd14, 6'd1,     // line ends at 457, not 456
                          6'd63, 6'd0, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63};
        foreach (directed_dots[k])
            send_update(directed_dots[k], k % 3);

        // Random phases, each under its own register setting
        for (p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                en  = 4'b0000;
                cmp = 8'hFF;
            end
            else if (p == 1)
            begin
                en  = 4'b1111;
                cmp = lmts_pkg::LINE_W'((sb.line + 2) % lmts_pkg::LINES_PER_FRAME);
            end
            else
            begin
                en = 4'($urandom);
                r  = $urandom_range(0, 9);
                if (r < 6)
                    cmp = lmts_pkg::LINE_W'((int'(sb.line) + $urandom_range(0, 24))
                                            % lmts_pkg::LINES_PER_FRAME);
                else if (r < 8)
                    cmp = (r == 6) ? lmts_pkg::LINE_W'(lmts_pkg::VISIBLE_LINES)
                                   : lmts_pkg::LINE_W'(lmts_pkg::LINES_PER_FRAME - 1);
                else
                    cmp = lmts_pkg::LINE_W'($urandom);
            end
            program_regs(en[0], en[1], en[2], en[3], cmp);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_update(pick_dots(), no_gaps ? 0 : pick_gap());
        end
        s_tvalid <= 1'b0;

        // Drain, then let the pipeline settle
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("updates sent %0d, results checked %0d, highest line %0d, frame wraps %0d",
                 sb.n_updates, sb.n_checked, sb.max_line, sb.n_wraps);
        $display("vblank entries %0d, line-ready pulses %0d, stat interrupts %0d, matches %0d",
                 sb.n_vblank, sb.n_ready, sb.n_stat, sb.n_match);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("lcd_mode_timing_sequencer_core_tb: PASS");
        else
            $display("lcd_mode_timing_sequencer_core_tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/lmts_pkg.sv
hdl/lmts_cfg_regs.sv
hdl/lmts_step.sv
hdl/lcd_mode_timing_sequencer_core.sv
hdl/lmts_checker.sv
test/lcd_mode_timing_sequencer_core_tb.sv
